/* rtl/core/sha256c_pkg.sv */
// Shared constants, types and round functions for the SHA-256 compression unit.
`timescale 1ns / 1ps
`default_nettype none

package sha256c_pkg;

  localparam int CHAIN_WORDS = 8;
  localparam int BLOCK_WORDS = 16;
  localparam int ROUNDS      = 64;

  localparam int CHAIN_IDX_W = $clog2(CHAIN_WORDS);
  localparam int BLOCK_CNT_W = $clog2(BLOCK_WORDS);
  localparam int ROUND_IDX_W = $clog2(ROUNDS);

  localparam logic OP_LOAD_WORD  = 1'b0;
  localparam logic OP_INIT_CHAIN = 1'b1;

  localparam logic [31:0] INIT_HASH [CHAIN_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                   load_word;
    logic                   init_chain;
    logic                   start;
    logic                   round;
    logic                   add;
    logic [ROUND_IDX_W-1:0] round_idx;
    logic [CHAIN_IDX_W-1:0] out_idx;
  } cmd_t;

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

`default_nettype wire

/* rtl/core/sha256_compression_unit.sv */
// Top level of the SHA-256 compression unit.
// The input channel (in_valid, in_stall, op, message_word) takes one command per
// transfer. With op low the transfer loads one 32-bit big-endian message word into
// the block buffer; with op high it reloads the chaining value with the standard
// initial hash and leaves a partly loaded block untouched. Neither case gives output.
// The sixteenth word of a block starts compression: the rounds run in ST_ROUND,
// the result is added into the chain in ST_ADD, then the eight chain words leave
// on the output channel (out_valid, out_stall, hash_word, last_word), word 0
// first, with last_word high on the eighth. Loading, rounds, addition and output
// of a block do not overlap, so a new block waits until its hash is delivered.
// While the rounds run and until the last hash word is taken, in_stall is high.
// A stalled receiver holds the current hash word steady and delays the rest.
// Synchronous reset loads the initial hash, clears the word count and returns
// the controller to idle; block buffer contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module sha256_compression_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        op,
  input  wire logic [31:0] message_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      hash_word,
  output logic             last_word
);
  import sha256c_pkg::*;

  cmd_t cmd;

  sha256c_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  sha256c_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .message_word (message_word),
    .hash_word    (hash_word),
    .last_word    (last_word)
  );

endmodule

`default_nettype wire

/* rtl/core/sha256c_datapath.sv */
// Datapath: chaining value, message schedule window and round registers.
`timescale 1ns / 1ps
`default_nettype none

module sha256c_datapath (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire sha256c_pkg::cmd_t  cmd,
  input  wire logic [31:0]        message_word,
  output logic [31:0]             hash_word,
  output logic                    last_word
);
  import sha256c_pkg::*;

  logic [31:0] chain [CHAIN_WORDS];
  logic [31:0] sched [BLOCK_WORDS];
  logic [31:0] work  [CHAIN_WORDS];

  logic [31:0] sched_new;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] choose;
  logic [31:0] major;

  // The window holds W[t] .. W[t+15]; the next word is W[t+16].
  assign sched_new = sched[0] + small_sigma0(sched[1]) + sched[9] + small_sigma1(sched[14]);

  assign choose = (work[4] & work[5]) ^ (~work[4] & work[6]);
  assign major  = (work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]);
  assign t1     = work[7] + big_sigma1(work[4]) + choose + ROUND_K[cmd.round_idx] + sched[0];
  assign t2     = big_sigma0(work[0]) + major;

  always_ff @(posedge clk) begin
    if (rst) begin
      chain <= INIT_HASH;
    end else if (cmd.init_chain) begin
      chain <= INIT_HASH;
    end else if (cmd.add) begin
      for (int i = 0; i < CHAIN_WORDS; i++) begin
        chain[i] <= chain[i] + work[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_word) begin
      for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
        sched[i] <= sched[i + 1];
      end
      sched[BLOCK_WORDS - 1] <= message_word;
    end else if (cmd.round) begin
      for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
        sched[i] <= sched[i + 1];
      end
      sched[BLOCK_WORDS - 1] <= sched_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      work <= chain;
    end else if (cmd.round) begin
      work[7] <= work[6];
      work[6] <= work[5];
      work[5] <= work[4];
      work[4] <= work[3] + t1;
      work[3] <= work[2];
      work[2] <= work[1];
      work[1] <= work[0];
      work[0] <= t1 + t2;
    end
  end

  assign hash_word = chain[cmd.out_idx];
  assign last_word = (cmd.out_idx == CHAIN_IDX_W'(CHAIN_WORDS - 1));

endmodule

`default_nettype wire

/* rtl/core/sha256c_ctrl.sv */
// Controller: word counting, round sequencing and output run state machine.
`timescale 1ns / 1ps
`default_nettype none

module sha256c_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               op,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output sha256c_pkg::cmd_t       cmd
);
  import sha256c_pkg::*;

  state_t                 state;
  state_t                 state_next;
  logic [BLOCK_CNT_W-1:0] words_cnt;
  logic [BLOCK_CNT_W-1:0] words_cnt_next;
  logic [ROUND_IDX_W-1:0] round_cnt;
  logic [ROUND_IDX_W-1:0] round_cnt_next;
  logic [CHAIN_IDX_W-1:0] out_cnt;
  logic [CHAIN_IDX_W-1:0] out_cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      words_cnt <= '0;
      round_cnt <= '0;
      out_cnt   <= '0;
    end else begin
      state     <= state_next;
      words_cnt <= words_cnt_next;
      round_cnt <= round_cnt_next;
      out_cnt   <= out_cnt_next;
    end
  end

  always_comb begin
    state_next     = state;
    words_cnt_next = words_cnt;
    round_cnt_next = round_cnt;
    out_cnt_next   = out_cnt;
    in_stall       = 1'b1;
    out_valid      = 1'b0;
    cmd            = '0;
    cmd.round_idx  = round_cnt;
    cmd.out_idx    = out_cnt;

    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (op == OP_INIT_CHAIN) begin
            cmd.init_chain = 1'b1;
          end else begin
            cmd.load_word  = 1'b1;
            words_cnt_next = words_cnt + 1'b1;
            // The sixteenth word completes the block; the chain is copied now.
            if (words_cnt == BLOCK_CNT_W'(BLOCK_WORDS - 1)) begin
              cmd.start      = 1'b1;
              round_cnt_next = '0;
              state_next     = ST_ROUND;
            end
          end
        end
      end
      ST_ROUND: begin
        cmd.round      = 1'b1;
        round_cnt_next = round_cnt + 1'b1;
        if (round_cnt == ROUND_IDX_W'(ROUNDS - 1)) begin
          state_next = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd.add      = 1'b1;
        out_cnt_next = '0;
        state_next   = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          out_cnt_next = out_cnt + 1'b1;
          if (out_cnt == CHAIN_IDX_W'(CHAIN_WORDS - 1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/sha256c_checker.sv */
// Port-level checker for the SHA-256 compression unit and its bind statement.
`timescale 1ns / 1ps
`default_nettype none

module sha256c_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] hash_word,
  input wire logic        last_word
);

  // A stalled hash word stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(hash_word) && $stable(last_word))
    else $error("hash word changed while stalled");

  // No input is taken while a hash run is being delivered.
  a_no_in_during_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open while hash words are pending");

  // The run ends after the transfer of the word marked last.
  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last_word |=> !out_valid && !in_stall)
    else $error("output run did not end after last word");

  // No input transfer, word load or initial-hash command, produces output in the following cycle.
  a_no_out_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !out_valid)
    else $error("output appeared right after an input transfer");

endmodule

bind sha256_compression_unit sha256c_checker u_sha256c_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .hash_word (hash_word),
  .last_word (last_word)
);

`default_nettype wire
